// ----- rtl/vrot_pkg.sv -----
// Vector axis rotate: shared types, constants and the arctangent table.
// No dependencies; used by every module under rtl/.
package vrot_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;

    // phase units per input unit (2^32 units per full turn)
    localparam logic [29:0] RAD_TO_PHASE = 30'd683565276;
    localparam logic [29:0] DEG_TO_PHASE = 30'd11930465;

    // CORDIC gain 0.607252935 in Q2.30
    localparam int CW = 34;   // x/y datapath width
    localparam int ZW = 34;   // residual angle width
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [31:0] QUARTER_POS = 32'sd1073741824;
    localparam logic signed [31:0] QUARTER_NEG = -32'sd1073741824;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef struct packed {
        axis_t              cmd;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] angle;
        logic               angle_in_radians;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } result_t;

    // CORDIC working set
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rot_t;

    // atan(2^-i) in binary-angle units
    function automatic logic [29:0] atan_phase(input int idx);
        logic [29:0] a;
        case (idx)
            0:       a = 30'd536870912;
            1:       a = 30'd316933406;
            2:       a = 30'd167458907;
            3:       a = 30'd85004756;
            4:       a = 30'd42667331;
            5:       a = 30'd21354465;
            6:       a = 30'd10679838;
            7:       a = 30'd5340245;
            8:       a = 30'd2670163;
            9:       a = 30'd1335087;
            10:      a = 30'd667544;
            11:      a = 30'd333772;
            12:      a = 30'd166886;
            13:      a = 30'd83443;
            14:      a = 30'd41722;
            15:      a = 30'd20861;
            16:      a = 30'd10430;
            17:      a = 30'd5215;
            18:      a = 30'd2608;
            19:      a = 30'd1304;
            20:      a = 30'd652;
            21:      a = 30'd326;
            22:      a = 30'd163;
            23:      a = 30'd81;
            24:      a = 30'd41;
            25:      a = 30'd20;
            26:      a = 30'd10;
            27:      a = 30'd5;
            28:      a = 30'd3;
            29:      a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/vrot_phase.sv -----
// Angle to binary phase: scale multiply, round, quarter-turn fold.
// Two register stages. Depends on vrot_pkg.
module vrot_phase #(
    parameter int FRAC_BITS = vrot_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  vrot_pkg::item_t in_item,
    output logic            out_valid,
    output vrot_pkg::item_t out_item,
    output vrot_pkg::rot_t  out_rot
);

    localparam logic [63:0] ROUND = 64'd1 << (FRAC_BITS - 1);

    // stage 1: angle * scale
    logic                     v1_reg;
    vrot_pkg::item_t          item1_reg;
    logic signed [62:0]       prod_reg;
    logic signed [62:0]       prod_next;
    logic        [29:0]       scale;

    // stage 2: round, fold
    logic                     v2_reg;
    vrot_pkg::item_t          item2_reg;
    vrot_pkg::rot_t           rot_reg;
    vrot_pkg::rot_t           rot_next;
    logic        [63:0]       rnd;
    logic signed [31:0]       phase;
    logic                     far;

    always_comb
    begin
        scale     = in_item.angle_in_radians ? vrot_pkg::RAD_TO_PHASE
                                             : vrot_pkg::DEG_TO_PHASE;
        prod_next = in_item.angle * $signed({1'b0, scale});
    end

    always_comb
    begin
        rnd   = {prod_reg[62], prod_reg} + ROUND;
        phase = $signed(rnd[FRAC_BITS+31 -: 32]);
        far   = (phase > vrot_pkg::QUARTER_POS) || (phase < vrot_pkg::QUARTER_NEG);
        rot_next.x    = vrot_pkg::CORDIC_GAIN;
        rot_next.y    = '0;
        rot_next.z    = vrot_pkg::ZW'(far ? $signed({~phase[31], phase[30:0]}) : phase);
        rot_next.flip = far;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= in_item;
        prod_reg  <= prod_next;
        item2_reg <= item1_reg;
        rot_reg   <= rot_next;
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_rot   = rot_reg;

endmodule

// ----- rtl/vrot_cordic_stage.sv -----
// One rotation-mode CORDIC iteration, registered.
// Depends on vrot_pkg.
module vrot_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  vrot_pkg::item_t in_item,
    input  vrot_pkg::rot_t  in_rot,
    output logic            out_valid,
    output vrot_pkg::item_t out_item,
    output vrot_pkg::rot_t  out_rot
);

    localparam logic signed [vrot_pkg::ZW-1:0] ATAN =
        $signed({{(vrot_pkg::ZW-30){1'b0}}, vrot_pkg::atan_phase(IDX)});

    logic                              valid_reg;
    vrot_pkg::item_t                   item_reg;
    vrot_pkg::rot_t                    rot_reg;
    vrot_pkg::rot_t                    rot_next;
    logic signed [vrot_pkg::CW-1:0]    xs;
    logic signed [vrot_pkg::CW-1:0]    ys;

    always_comb
    begin
        xs            = in_rot.x >>> IDX;
        ys            = in_rot.y >>> IDX;
        rot_next.flip = in_rot.flip;
        if (!in_rot.z[vrot_pkg::ZW-1])
        begin
            rot_next.x = in_rot.x - ys;
            rot_next.y = in_rot.y + xs;
            rot_next.z = in_rot.z - ATAN;
        end
        else
        begin
            rot_next.x = in_rot.x + ys;
            rot_next.y = in_rot.y - xs;
            rot_next.z = in_rot.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= in_item;
        rot_reg  <= rot_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rot   = rot_reg;

endmodule

// ----- rtl/vrot_mix.sv -----
// Applies cos/sin to the selected component pair: sign fix, multiply,
// sum and round, saturate. Four register stages. Depends on vrot_pkg.
module vrot_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  vrot_pkg::item_t   in_item,
    input  vrot_pkg::rot_t    in_rot,
    output logic              out_valid,
    output vrot_pkg::result_t out_result
);

    localparam logic signed [64:0] RND    = 65'sd536870912;
    localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
    localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

    // stage T: signed cos/sin and operand pair
    logic                      vt_reg;
    vrot_pkg::item_t           it_reg;
    logic signed [31:0]        u_reg, v_reg, c_reg, s_reg;
    logic signed [31:0]        u_next, v_next, c_next, s_next;
    logic signed [vrot_pkg::CW-1:0] c_full, s_full;

    // stage P: products
    logic                      vp_reg;
    vrot_pkg::item_t           ip_reg;
    logic signed [63:0]        p_uc_reg, p_vs_reg, p_us_reg, p_vc_reg;

    // stage S: sums with rounding offset
    logic                      vs_reg;
    vrot_pkg::item_t           is_reg;
    logic signed [64:0]        sa_reg, sb_reg;

    // stage O: saturate and place
    logic                      vo_reg;
    vrot_pkg::result_t         res_reg;
    vrot_pkg::result_t         res_next;
    logic signed [34:0]        ra, rb;
    logic signed [31:0]        qa, qb;
    logic                      sat_a, sat_b;

    // Y axis uses the transposed sine sign
    always_comb
    begin
        c_full = in_rot.flip ? -in_rot.x : in_rot.x;
        s_full = (in_rot.flip ^ (in_item.cmd == vrot_pkg::AXIS_Y)) ? -in_rot.y : in_rot.y;
        c_next = c_full[31:0];
        s_next = s_full[31:0];
        case (in_item.cmd)
            vrot_pkg::AXIS_X:
            begin
                u_next = in_item.vec_y;
                v_next = in_item.vec_z;
            end
            vrot_pkg::AXIS_Y:
            begin
                u_next = in_item.vec_x;
                v_next = in_item.vec_z;
            end
            default:
            begin
                u_next = in_item.vec_x;
                v_next = in_item.vec_y;
            end
        endcase
    end

    always_comb
    begin
        ra    = 35'(sa_reg >>> 30);
        rb    = 35'(sb_reg >>> 30);
        sat_a = (ra > SAT_HI) || (ra < SAT_LO);
        sat_b = (rb > SAT_HI) || (rb < SAT_LO);
        qa    = (ra > SAT_HI) ? 32'sh7fffffff : (ra < SAT_LO) ? 32'sh80000000 : ra[31:0];
        qb    = (rb > SAT_HI) ? 32'sh7fffffff : (rb < SAT_LO) ? 32'sh80000000 : rb[31:0];
        res_next.out_x     = is_reg.vec_x;
        res_next.out_y     = is_reg.vec_y;
        res_next.out_z     = is_reg.vec_z;
        res_next.saturated = 1'b0;
        case (is_reg.cmd)
            vrot_pkg::AXIS_X:
            begin
                res_next.out_y     = qa;
                res_next.out_z     = qb;
                res_next.saturated = sat_a | sat_b;
            end
            vrot_pkg::AXIS_Y:
            begin
                res_next.out_x     = qa;
                res_next.out_z     = qb;
                res_next.saturated = sat_a | sat_b;
            end
            vrot_pkg::AXIS_Z:
            begin
                res_next.out_x     = qa;
                res_next.out_y     = qb;
                res_next.saturated = sat_a | sat_b;
            end
            default:
            begin
                res_next.saturated = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg <= 1'b0;
            vp_reg <= 1'b0;
            vs_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            vt_reg <= in_valid;
            vp_reg <= vt_reg;
            vs_reg <= vp_reg;
            vo_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= in_item;
        u_reg    <= u_next;
        v_reg    <= v_next;
        c_reg    <= c_next;
        s_reg    <= s_next;
        ip_reg   <= it_reg;
        p_uc_reg <= u_reg * c_reg;
        p_vs_reg <= v_reg * s_reg;
        p_us_reg <= u_reg * s_reg;
        p_vc_reg <= v_reg * c_reg;
        is_reg   <= ip_reg;
        sa_reg   <= 65'(p_uc_reg) - 65'(p_vs_reg) + RND;
        sb_reg   <= 65'(p_us_reg) + 65'(p_vc_reg) + RND;
        res_reg  <= res_next;
    end

    assign out_valid  = vo_reg;
    assign out_result = res_reg;

endmodule

// ----- rtl/vector_axis_rotate_unit.sv -----
// Top level of the vector axis rotate unit: phase front end, CORDIC chain,
// rotation back end. Depends on vrot_pkg, vrot_phase, vrot_cordic_stage, vrot_mix.
//
//  channel   ports                 transfer when
//  -------   -------------------   ------------------------------
//  command   start, busy, item     start high and busy low at clk
//  result    done, result          done high for one cycle
//
// Fully pipelined: one command per cycle, busy is never raised.
// A command passes through the angle scaling and folding stages, a CORDIC stage
// for each iteration, then the sign fix, multiply, sum and saturate stages.
// Reset clears only the valid bits travelling with each stage.
// The receiver cannot stall, so the pipeline never holds.
module vector_axis_rotate_unit #(
    parameter int CORDIC_STAGES = vrot_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = vrot_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vrot_pkg::item_t   item,
    output logic              done,
    output vrot_pkg::result_t result
);

    localparam int LATENCY = CORDIC_STAGES + 6;

    logic                 accept;

    // CORDIC chain taps; index 0 is the phase front end output
    logic                 chain_valid [CORDIC_STAGES+1];
    vrot_pkg::item_t      chain_item  [CORDIC_STAGES+1];
    vrot_pkg::rot_t       chain_rot   [CORDIC_STAGES+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    vrot_phase #(
        .FRAC_BITS (FRAC_BITS)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0]),
        .out_rot   (chain_rot[0])
    );

    // one shift-and-add iteration per stage
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        vrot_cordic_stage #(
            .IDX (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .in_rot    (chain_rot[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1]),
            .out_rot   (chain_rot[g+1])
        );
    end

    vrot_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[CORDIC_STAGES]),
        .in_item    (chain_item[CORDIC_STAGES]),
        .in_rot     (chain_rot[CORDIC_STAGES]),
        .out_valid  (done),
        .out_result (result)
    );

`ifndef SYNTHESIS
    // every result traces back to an accepted command
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without matching command");

    // folded phase stays within a quarter turn either way
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |->
            (chain_rot[0].z <= vrot_pkg::ZW'(vrot_pkg::QUARTER_POS)) &&
            (chain_rot[0].z >= vrot_pkg::ZW'(vrot_pkg::QUARTER_NEG)))
        else $error("phase fold out of range");
`endif

endmodule
